/* rtl/ltcd_pkg.sv */
// Shared types and constants for the LRU tag cache directory.
// No dependencies; used by ltcd_ctrl, ltcd_datapath and the top level.
package ltcd_pkg;

	localparam int TAG_W      = 64;
	localparam int STAMP_W    = 32;
	localparam int DIM_W      = 32;
	localparam int BPP_W      = 16;
	localparam int OUT_W_W    = 9;
	localparam int OUT_H_W    = 8;
	localparam int SLOT_OUT_W = 3;

	localparam logic OP_ACCESS = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	localparam logic [BPP_W-1:0] BPP_REQUIRED = 16'd16;
	localparam logic [DIM_W-1:0] MAX_WIDTH    = 32'd320;
	localparam logic [DIM_W-1:0] MAX_HEIGHT   = 32'd240;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;  // latch the accepted item and clear the scan results
		logic rd_en;    // read one slot from the directory arrays
		logic commit;   // update the directory and load the result register
	} cmd_t;

endpackage

/* rtl/ltcd_ctrl.sv */
// Controller for the LRU tag cache directory: state machine, scan counter
// and result-register handshake. Depends on ltcd_pkg.
module ltcd_ctrl #(
	parameter int SLOT_COUNT = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          opcode,
	output logic                          req_stall,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output ltcd_pkg::cmd_t                cmd,
	output logic [$clog2(SLOT_COUNT)-1:0] rd_addr
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             rsp_valid_q;
	logic             scan_end;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign scan_end  = (cnt_q == CNT_W'(SLOT_COUNT));
	assign rd_addr   = cnt_q[IDX_W-1:0];

	assign cmd.capture = (state_q == ST_IDLE) && req_valid;
	assign cmd.rd_en   = (state_q == ST_SCAN) && !scan_end;
	assign cmd.commit  = (state_q == ST_COMMIT) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						cnt_q   <= '0;
						state_q <= (opcode == ltcd_pkg::OP_FLUSH) ? ST_COMMIT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					// the scan state is held after the last read so that its data can be evaluated
					if (scan_end) begin
						state_q <= ST_COMMIT;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_COMMIT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> req_stall)
		else $error("item accepted while another is in progress");

	a_scan_to_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && !cmd.rd_en |=> (state_q == ST_COMMIT))
		else $error("scan did not finish into commit");

	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid)
		else $error("commit did not present a result");
`endif

endmodule

/* rtl/ltcd_datapath.sv */
// Datapath for the LRU tag cache directory: slot arrays, scan evaluation,
// use counter, directory update and result register. Depends on ltcd_pkg.
module ltcd_datapath #(
	parameter int SLOT_COUNT = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ltcd_pkg::cmd_t                      cmd,
	input  logic [$clog2(SLOT_COUNT)-1:0]       rd_addr,
	input  logic                                opcode,
	input  logic [ltcd_pkg::TAG_W-1:0]          key_tag,
	input  logic                                load_ok,
	input  logic [ltcd_pkg::DIM_W-1:0]          bmp_width,
	input  logic [ltcd_pkg::DIM_W-1:0]          bmp_height,
	input  logic [ltcd_pkg::BPP_W-1:0]          bits_per_pixel,
	output logic                                hit,
	output logic                                success,
	output logic [ltcd_pkg::SLOT_OUT_W-1:0]     slot_index,
	output logic [ltcd_pkg::OUT_W_W-1:0]        out_width,
	output logic [ltcd_pkg::OUT_H_W-1:0]        out_height,
	output logic                                evicted
);

	localparam int IDX_W = $clog2(SLOT_COUNT);

	// directory arrays
	logic [ltcd_pkg::TAG_W-1:0]   tag_mem    [SLOT_COUNT];
	logic [ltcd_pkg::STAMP_W-1:0] stamp_mem  [SLOT_COUNT];
	logic [ltcd_pkg::OUT_W_W-1:0] width_mem  [SLOT_COUNT];
	logic [ltcd_pkg::OUT_H_W-1:0] height_mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]        valid_q;
	logic [ltcd_pkg::STAMP_W-1:0] use_cnt_q;

	// captured item
	logic                         flush_q;
	logic [ltcd_pkg::TAG_W-1:0]   key_q;
	logic                         good_q;
	logic [ltcd_pkg::OUT_W_W-1:0] width_q;
	logic [ltcd_pkg::OUT_H_W-1:0] height_q;

	// read stage
	logic                         eval_en_s1;
	logic [IDX_W-1:0]             eval_idx_s1;
	logic                         eval_vld_s1;
	logic [ltcd_pkg::TAG_W-1:0]   rd_tag_s1;
	logic [ltcd_pkg::STAMP_W-1:0] rd_stamp_s1;
	logic [ltcd_pkg::OUT_W_W-1:0] rd_width_s1;
	logic [ltcd_pkg::OUT_H_W-1:0] rd_height_s1;

	// scan results
	logic                         hit_q;
	logic [IDX_W-1:0]             hit_idx_q;
	logic [ltcd_pkg::OUT_W_W-1:0] hit_width_q;
	logic [ltcd_pkg::OUT_H_W-1:0] hit_height_q;
	logic                         free_found_q;
	logic [IDX_W-1:0]             free_idx_q;
	logic                         old_found_q;
	logic [IDX_W-1:0]             old_idx_q;
	logic [ltcd_pkg::STAMP_W-1:0] old_stamp_q;

	// result register
	logic                            res_hit_q;
	logic                            res_success_q;
	logic [ltcd_pkg::SLOT_OUT_W-1:0] res_slot_q;
	logic [ltcd_pkg::OUT_W_W-1:0]    res_width_q;
	logic [ltcd_pkg::OUT_H_W-1:0]    res_height_q;
	logic                            res_evicted_q;

	logic                         load_good;
	logic                         tag_match;
	logic                         older;
	logic [IDX_W-1:0]             victim_idx;
	logic [IDX_W-1:0]             wr_idx;
	logic [ltcd_pkg::STAMP_W-1:0] next_stamp;
	logic                         stamp_we;
	logic                         entry_we;

	assign load_good = load_ok && (bits_per_pixel == ltcd_pkg::BPP_REQUIRED)
		&& (bmp_width != '0) && (bmp_width <= ltcd_pkg::MAX_WIDTH)
		&& (bmp_height != '0) && (bmp_height <= ltcd_pkg::MAX_HEIGHT);

	assign tag_match  = eval_vld_s1 && (rd_tag_s1 == key_q);
	assign older      = !old_found_q || (rd_stamp_s1 < old_stamp_q);
	assign victim_idx = free_found_q ? free_idx_q : old_idx_q;
	assign wr_idx     = hit_q ? hit_idx_q : victim_idx;
	assign next_stamp = use_cnt_q + ltcd_pkg::STAMP_W'(1);
	assign stamp_we   = cmd.commit && !flush_q && (hit_q || good_q);
	assign entry_we   = cmd.commit && !flush_q && !hit_q && good_q;

	// arrays: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (stamp_we) begin
			stamp_mem[wr_idx] <= next_stamp;
		end
		if (entry_we) begin
			tag_mem[wr_idx]    <= key_q;
			width_mem[wr_idx]  <= width_q;
			height_mem[wr_idx] <= height_q;
		end
		if (cmd.rd_en) begin
			rd_tag_s1    <= tag_mem[rd_addr];
			rd_stamp_s1  <= stamp_mem[rd_addr];
			rd_width_s1  <= width_mem[rd_addr];
			rd_height_s1 <= height_mem[rd_addr];
			eval_idx_s1  <= rd_addr;
			eval_vld_s1  <= valid_q[rd_addr];
		end
	end

	// item payload and scan payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			flush_q  <= (opcode == ltcd_pkg::OP_FLUSH);
			key_q    <= key_tag;
			good_q   <= load_good;
			width_q  <= bmp_width[ltcd_pkg::OUT_W_W-1:0];
			height_q <= bmp_height[ltcd_pkg::OUT_H_W-1:0];
		end
		if (eval_en_s1) begin
			if (tag_match && !hit_q) begin
				hit_idx_q    <= eval_idx_s1;
				hit_width_q  <= rd_width_s1;
				hit_height_q <= rd_height_s1;
			end
			if (!eval_vld_s1 && !free_found_q) begin
				free_idx_q <= eval_idx_s1;
			end
			// strict compare keeps the lowest index on equal stamps
			if (eval_vld_s1 && older) begin
				old_idx_q   <= eval_idx_s1;
				old_stamp_q <= rd_stamp_s1;
			end
		end
		if (cmd.commit) begin
			if (flush_q) begin
				res_hit_q     <= 1'b0;
				res_success_q <= 1'b0;
				res_slot_q    <= '0;
				res_width_q   <= '0;
				res_height_q  <= '0;
				res_evicted_q <= 1'b0;
			end else if (hit_q) begin
				res_hit_q     <= 1'b1;
				res_success_q <= 1'b1;
				res_slot_q    <= ltcd_pkg::SLOT_OUT_W'(hit_idx_q);
				res_width_q   <= hit_width_q;
				res_height_q  <= hit_height_q;
				res_evicted_q <= 1'b0;
			end else begin
				res_hit_q     <= 1'b0;
				res_success_q <= good_q;
				res_slot_q    <= ltcd_pkg::SLOT_OUT_W'(victim_idx);
				res_width_q   <= good_q ? width_q : '0;
				res_height_q  <= good_q ? height_q : '0;
				res_evicted_q <= !free_found_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			use_cnt_q    <= '0;
			eval_en_s1   <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			old_found_q  <= 1'b0;
		end else begin
			eval_en_s1 <= cmd.rd_en;
			if (cmd.capture) begin
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
				old_found_q  <= 1'b0;
			end else if (eval_en_s1) begin
				if (tag_match) begin
					hit_q <= 1'b1;
				end
				if (!eval_vld_s1) begin
					free_found_q <= 1'b1;
				end
				if (eval_vld_s1) begin
					old_found_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				if (flush_q) begin
					valid_q <= '0;
				end else if (!hit_q) begin
					// drop the victim; refill it only with an acceptable load
					valid_q[victim_idx] <= good_q;
				end
			end
			if (stamp_we) begin
				use_cnt_q <= next_stamp;
			end
		end
	end

	assign hit        = res_hit_q;
	assign success    = res_success_q;
	assign slot_index = res_slot_q;
	assign out_width  = res_width_q;
	assign out_height = res_height_q;
	assign evicted    = res_evicted_q;

`ifndef ASSERT_OFF
	a_hit_slot_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && !flush_q && hit_q |-> valid_q[hit_idx_q])
		else $error("hit slot is not valid at commit");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && flush_q |=> (valid_q == '0))
		else $error("flush left a valid slot");

	a_lru_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && !flush_q && !hit_q && !free_found_q |-> (valid_q == '1))
		else $error("LRU victim taken while a slot was free");
`endif

endmodule

/* rtl/lru_tag_cache_directory.sv */
// Top level of the LRU tag cache directory: joins controller and datapath.
// Depends on ltcd_pkg, ltcd_ctrl and ltcd_datapath.
//
//   channel   handshake              payload
//   request   req_valid / req_stall  opcode, key_tag, load_ok, bmp_width,
//                                    bmp_height, bits_per_pixel
//   response  rsp_valid / rsp_stall  hit, success, slot_index, out_width,
//                                    out_height, evicted
//
// An access reads one slot per cycle from the directory arrays, then the commit
// updates them; a flush skips the scan and goes straight to the commit.
// Reset invalidates every slot and zeroes the counter.
// A held result stalls only the commit; the next item is taken and scanned
// while the result register waits.
module lru_tag_cache_directory #(
	parameter int SLOT_COUNT = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                opcode,
	input  logic [ltcd_pkg::TAG_W-1:0]          key_tag,
	input  logic                                load_ok,
	input  logic [ltcd_pkg::DIM_W-1:0]          bmp_width,
	input  logic [ltcd_pkg::DIM_W-1:0]          bmp_height,
	input  logic [ltcd_pkg::BPP_W-1:0]          bits_per_pixel,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic                                hit,
	output logic                                success,
	output logic [ltcd_pkg::SLOT_OUT_W-1:0]     slot_index,
	output logic [ltcd_pkg::OUT_W_W-1:0]        out_width,
	output logic [ltcd_pkg::OUT_H_W-1:0]        out_height,
	output logic                                evicted
);

	localparam int IDX_W = $clog2(SLOT_COUNT);

	ltcd_pkg::cmd_t   cmd;
	logic [IDX_W-1:0] rd_addr;

	ltcd_ctrl #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.opcode   (opcode),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.cmd      (cmd),
		.rd_addr  (rd_addr)
	);

	ltcd_datapath #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.rd_addr       (rd_addr),
		.opcode        (opcode),
		.key_tag       (key_tag),
		.load_ok       (load_ok),
		.bmp_width     (bmp_width),
		.bmp_height    (bmp_height),
		.bits_per_pixel(bits_per_pixel),
		.hit           (hit),
		.success       (success),
		.slot_index    (slot_index),
		.out_width     (out_width),
		.out_height    (out_height),
		.evicted       (evicted)
	);

endmodule

/* sim/lru_tag_cache_directory_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for lru_tag_cache_directory: directed table, then random traffic.
// Depends on ltcd_pkg and the lru_tag_cache_directory RTL; a local directory model
// predicts the results of random items and untyped rows; typed rows give their own.
module lru_tag_cache_directory_tb;

	localparam int SLOT_COUNT   = 8;
	localparam int RANDOM_ITEMS = 530;
	localparam int TAG_POOL     = 12;
	localparam int CYCLE_LIMIT  = 300000;

	typedef struct packed {
		logic                            opcode;
		logic [ltcd_pkg::TAG_W-1:0]      tag;
		logic                            load_ok;
		logic [ltcd_pkg::DIM_W-1:0]      width;
		logic [ltcd_pkg::DIM_W-1:0]      height;
		logic [ltcd_pkg::BPP_W-1:0]      bpp;
	} asset_req_t;

	typedef struct packed {
		logic                            hit;
		logic                            success;
		logic [ltcd_pkg::SLOT_OUT_W-1:0] slot_index;
		logic [ltcd_pkg::OUT_W_W-1:0]    out_width;
		logic [ltcd_pkg::OUT_H_W-1:0]    out_height;
		logic                            evicted;
	} asset_rsp_t;

	typedef struct {
		asset_req_t req;
		bit         typed;
		asset_rsp_t want;
	} stim_row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            req_valid;
	logic                            req_stall;
	logic                            opcode;
	logic [ltcd_pkg::TAG_W-1:0]      key_tag;
	logic                            load_ok;
	logic [ltcd_pkg::DIM_W-1:0]      bmp_width;
	logic [ltcd_pkg::DIM_W-1:0]      bmp_height;
	logic [ltcd_pkg::BPP_W-1:0]      bits_per_pixel;
	logic                            rsp_valid;
	logic                            rsp_stall;
	logic                            hit;
	logic                            success;
	logic [ltcd_pkg::SLOT_OUT_W-1:0] slot_index;
	logic [ltcd_pkg::OUT_W_W-1:0]    out_width;
	logic [ltcd_pkg::OUT_H_W-1:0]    out_height;
	logic                            evicted;

	// Directory model state
	bit                           cached_valid [SLOT_COUNT];
	logic [ltcd_pkg::TAG_W-1:0]   cached_tag   [SLOT_COUNT];
	logic [ltcd_pkg::STAMP_W-1:0] cached_stamp [SLOT_COUNT];
	logic [ltcd_pkg::OUT_W_W-1:0] cached_width [SLOT_COUNT];
	logic [ltcd_pkg::OUT_H_W-1:0] cached_height[SLOT_COUNT];
	logic [ltcd_pkg::STAMP_W-1:0] use_count;

	asset_rsp_t                 pending_results[$];
	asset_rsp_t                 result_head;
	stim_row_t                  directed_rows[$];
	logic [ltcd_pkg::TAG_W-1:0] tag_pool[TAG_POOL];
	int                         mismatch_count;
	int                         cycle_count;
	bit                         calm;

	lru_tag_cache_directory #(
		.SLOT_COUNT(SLOT_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.opcode(opcode),
		.key_tag(key_tag),
		.load_ok(load_ok),
		.bmp_width(bmp_width),
		.bmp_height(bmp_height),
		.bits_per_pixel(bits_per_pixel),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.hit(hit),
		.success(success),
		.slot_index(slot_index),
		.out_width(out_width),
		.out_height(out_height),
		.evicted(evicted)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic asset_rsp_t predict_lookup(input asset_req_t r);
		asset_rsp_t o;
		int found;
		int victim;
		bit good;
		o = '0;
		if (r.opcode == ltcd_pkg::OP_FLUSH) begin
			for (int i = 0; i < SLOT_COUNT; i++)
				cached_valid[i] = 1'b0;
			return o;
		end
		found = -1;
		for (int i = 0; i < SLOT_COUNT; i++)
			if (found < 0 && cached_valid[i] && cached_tag[i] == r.tag)
				found = i;
		if (found >= 0) begin
			use_count = use_count + ltcd_pkg::STAMP_W'(1);
			cached_stamp[found] = use_count;
			o.hit = 1'b1;
			o.success = 1'b1;
			o.slot_index = ltcd_pkg::SLOT_OUT_W'(found);
			o.out_width = cached_width[found];
			o.out_height = cached_height[found];
			return o;
		end
		victim = -1;
		for (int i = 0; i < SLOT_COUNT; i++)
			if (victim < 0 && !cached_valid[i])
				victim = i;
		// full directory: oldest stamp goes, lowest index on ties
		if (victim < 0) begin
			victim = 0;
			for (int i = 1; i < SLOT_COUNT; i++)
				if (cached_stamp[i] < cached_stamp[victim])
					victim = i;
			cached_valid[victim] = 1'b0;
			o.evicted = 1'b1;
		end
		o.slot_index = ltcd_pkg::SLOT_OUT_W'(victim);
		good = r.load_ok && r.bpp == ltcd_pkg::BPP_REQUIRED && r.width != 0 &&
			r.height != 0 && r.width <= ltcd_pkg::MAX_WIDTH &&
			r.height <= ltcd_pkg::MAX_HEIGHT;
		if (good) begin
			cached_valid[victim] = 1'b1;
			cached_tag[victim] = r.tag;
			cached_width[victim] = r.width[ltcd_pkg::OUT_W_W-1:0];
			cached_height[victim] = r.height[ltcd_pkg::OUT_H_W-1:0];
			use_count = use_count + ltcd_pkg::STAMP_W'(1);
			cached_stamp[victim] = use_count;
			o.success = 1'b1;
			o.out_width = r.width[ltcd_pkg::OUT_W_W-1:0];
			o.out_height = r.height[ltcd_pkg::OUT_H_W-1:0];
		end
		return o;
	endfunction

	function automatic int pick_gap();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic asset_req_t acc(input logic [ltcd_pkg::TAG_W-1:0] tag,
		input logic ok, input logic [ltcd_pkg::DIM_W-1:0] w,
		input logic [ltcd_pkg::DIM_W-1:0] h, input logic [ltcd_pkg::BPP_W-1:0] bpp);
		asset_req_t r;
		r.opcode = ltcd_pkg::OP_ACCESS;
		r.tag = tag;
		r.load_ok = ok;
		r.width = w;
		r.height = h;
		r.bpp = bpp;
		return r;
	endfunction

	task automatic add_row(input asset_req_t r, input bit typed, input asset_rsp_t want);
		stim_row_t row;
		row.req = r;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	function automatic asset_req_t random_item();
		asset_req_t r;
		int roll;
		roll = $urandom_range(0, 99);
		r = acc(tag_pool[$urandom_range(0, TAG_POOL - 1)], 1'b1, $urandom_range(1, 320),
			$urandom_range(1, 240), ltcd_pkg::BPP_REQUIRED);
		if (roll < 4) begin
			r = acc({$urandom, $urandom}, 1'($urandom), $urandom, $urandom,
				ltcd_pkg::BPP_W'($urandom));
			r.opcode = ltcd_pkg::OP_FLUSH;
		end else if (roll < 10) begin
			// noise: unrelated tag, raw header fields
			r = acc({$urandom, $urandom}, 1'($urandom), $urandom, $urandom,
				ltcd_pkg::BPP_W'($urandom));
		end else if (roll < 28) begin
			case ($urandom_range(0, 5))
				0: r.load_ok = 1'b0;
				1: begin
					r.bpp = ltcd_pkg::BPP_W'($urandom);
					if (r.bpp == ltcd_pkg::BPP_REQUIRED)
						r.bpp = ~ltcd_pkg::BPP_REQUIRED;
				end
				2: r.width = '0;
				3: r.width = $urandom_range(0, 1) ? $urandom_range(321, 1023)
					: ($urandom | 32'h8000_0000);
				4: r.height = '0;
				default: r.height = $urandom_range(0, 1) ? $urandom_range(241, 511)
					: ($urandom | 32'h8000_0000);
			endcase
		end
		return r;
	endfunction

	task automatic offer(input asset_req_t r, input bit typed, input asset_rsp_t given);
		int gap;
		asset_rsp_t pred;
		gap = pick_gap();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		opcode <= r.opcode;
		key_tag <= r.tag;
		load_ok <= r.load_ok;
		bmp_width <= r.width;
		bmp_height <= r.height;
		bits_per_pixel <= r.bpp;
		do @(posedge clk); while (req_stall);
		pred = predict_lookup(r);
		pending_results.push_back(typed ? given : pred);
	endtask

	task automatic compare_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no item outstanding (slot_index %0d)", slot_index);
				mismatch_count++;
			end else begin
				result_head = pending_results.pop_front();
				compare_field("hit", result_head.hit, hit);
				compare_field("success", result_head.success, success);
				compare_field("slot_index", result_head.slot_index, slot_index);
				compare_field("out_width", result_head.out_width, out_width);
				compare_field("out_height", result_head.out_height, out_height);
				compare_field("evicted", result_head.evicted, evicted);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Response side back-pressure
	initial begin
		int hold;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			hold = pick_gap();
			if (hold != 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		mismatch_count = 0;
		cycle_count = 0;
		calm = 1'b0;
		use_count = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			cached_valid[i] = 1'b0;
			cached_tag[i] = '0;
			cached_stamp[i] = '0;
			cached_width[i] = '0;
			cached_height[i] = '0;
		end
		for (int i = 0; i < TAG_POOL; i++)
			tag_pool[i] = {$urandom, $urandom};

		arst_n <= 1'b0;
		req_valid <= 1'b0;
		opcode <= ltcd_pkg::OP_ACCESS;
		key_tag <= '0;
		load_ok <= 1'b0;
		bmp_width <= '0;
		bmp_height <= '0;
		bits_per_pixel <= '0;

		// flush on empty directory, first fills, hit, every reject reason
		add_row(acc('1, 1'b1, 32'd320, 32'd240, ltcd_pkg::BPP_REQUIRED), 1'b1, '0);
		directed_rows[0].req.opcode = ltcd_pkg::OP_FLUSH;
		add_row(acc(64'h0, 1'b1, 32'd320, 32'd240, ltcd_pkg::BPP_REQUIRED), 1'b1,
			'{1'b0, 1'b1, 3'd0, 9'd320, 8'd240, 1'b0});
		add_row(acc('1, 1'b1, 32'd1, 32'd1, ltcd_pkg::BPP_REQUIRED), 1'b1,
			'{1'b0, 1'b1, 3'd1, 9'd1, 8'd1, 1'b0});
		add_row(acc(64'h0, 1'b0, 32'd0, 32'd0, 16'd0), 1'b1,
			'{1'b1, 1'b1, 3'd0, 9'd320, 8'd240, 1'b0});
		add_row(acc(64'h0123_4567_89ab_cdef, 1'b0, 32'd100, 32'd100,
			ltcd_pkg::BPP_REQUIRED), 1'b1, '{1'b0, 1'b0, 3'd2, 9'd0, 8'd0, 1'b0});
		add_row(acc(64'h0123_4567_89ab_cdef, 1'b1, 32'd100, 32'd100, 16'd15), 1'b1,
			'{1'b0, 1'b0, 3'd2, 9'd0, 8'd0, 1'b0});
		add_row(acc(64'h0123_4567_89ab_cdef, 1'b1, 32'd100, 32'd100, 16'hffff), 1'b1,
			'{1'b0, 1'b0, 3'd2, 9'd0, 8'd0, 1'b0});
		add_row(acc(64'h0123_4567_89ab_cdef, 1'b1, 32'd0, 32'd100,
			ltcd_pkg::BPP_REQUIRED), 1'b1, '{1'b0, 1'b0, 3'd2, 9'd0, 8'd0, 1'b0});
		add_row(acc(64'h0123_4567_89ab_cdef, 1'b1, 32'd321, 32'd100,
			ltcd_pkg::BPP_REQUIRED), 1'b1, '{1'b0, 1'b0, 3'd2, 9'd0, 8'd0, 1'b0});
		add_row(acc(64'h0123_4567_89ab_cdef, 1'b1, 32'd100, 32'd0,
			ltcd_pkg::BPP_REQUIRED), 1'b1, '{1'b0, 1'b0, 3'd2, 9'd0, 8'd0, 1'b0});
		add_row(acc(64'h0123_4567_89ab_cdef, 1'b1, 32'd100, 32'd241,
			ltcd_pkg::BPP_REQUIRED), 1'b1, '{1'b0, 1'b0, 3'd2, 9'd0, 8'd0, 1'b0});
		add_row(acc(64'h0123_4567_89ab_cdef, 1'b1, '1, '1,
			ltcd_pkg::BPP_REQUIRED), 1'b1, '{1'b0, 1'b0, 3'd2, 9'd0, 8'd0, 1'b0});
		// low bits in range, upper bits set: must still reject
		add_row(acc(64'h0123_4567_89ab_cdef, 1'b1, 32'h201, 32'd10,
			ltcd_pkg::BPP_REQUIRED), 1'b1, '{1'b0, 1'b0, 3'd2, 9'd0, 8'd0, 1'b0});
		add_row(acc(64'h0123_4567_89ab_cdef, 1'b1, 32'd10, 32'h101,
			ltcd_pkg::BPP_REQUIRED), 1'b1, '{1'b0, 1'b0, 3'd2, 9'd0, 8'd0, 1'b0});
		// fill the rest, then force LRU evictions
		for (int i = 0; i < SLOT_COUNT - 2; i++)
			add_row(acc(64'h10 + i, 1'b1, 32'd40 * (i + 1), 32'd30 * (i + 1),
				ltcd_pkg::BPP_REQUIRED), 1'b0, '0);
		add_row(acc(64'h20, 1'b1, 32'd7, 32'd9, ltcd_pkg::BPP_REQUIRED), 1'b0, '0);
		add_row(acc('1, 1'b1, 32'd2, 32'd3, ltcd_pkg::BPP_REQUIRED), 1'b0, '0);
		add_row(acc(64'h20, 1'b0, 32'd0, 32'd0, 16'd0), 1'b0, '0);
		add_row(acc('1, 1'b1, 32'd320, 32'd240, ltcd_pkg::BPP_REQUIRED), 1'b1, '0);
		directed_rows[directed_rows.size() - 1].req.opcode = ltcd_pkg::OP_FLUSH;
		add_row(acc(64'h20, 1'b1, 32'd5, 32'd7, ltcd_pkg::BPP_REQUIRED), 1'b1,
			'{1'b0, 1'b1, 3'd0, 9'd5, 8'd7, 1'b0});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k])
			offer(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			calm = (k % 128) < 20;
			offer(random_item(), 1'b0, '0);
		end
		calm = 1'b0;
		req_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SLOT_COUNT + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* lru_tag_cache_directory.f */
rtl/ltcd_pkg.sv
rtl/ltcd_ctrl.sv
rtl/ltcd_datapath.sv
rtl/lru_tag_cache_directory.sv
sim/lru_tag_cache_directory_tb.sv
